// ===== design/pvr_texel_address_generator_top_defines.svh =====
// Assertion macros shared by the texel address generator modules.
// In synthesis builds the macros expand to nothing.
`ifndef PVR_TEXEL_ADDRESS_GENERATOR_TOP_DEFINES_SVH
`define PVR_TEXEL_ADDRESS_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside reset.
`define PVR_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("texel address generator assertion failed");

// Antecedent in one cycle implies the consequent in the next.
`define PVR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("texel address generator assertion failed");

`else

`define PVR_ASSERT(lbl, clk, rstn, prop)
`define PVR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== design/pvrtag_pkg.sv =====
`default_nettype none

package pvrtag_pkg;

	localparam int unsigned COORD_W = 10;
	localparam int unsigned SIDE_W  = 4;
	localparam int unsigned MODE_W  = 3;
	localparam int unsigned ADDR_W  = 22;
	localparam int unsigned SLOT_W  = 2;
	localparam int unsigned IDX_W   = 2 * COORD_W;
	localparam int unsigned BASE_W  = 20;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 4;

	// Register indexes on the configuration channel.
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_LOG2  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOG2 = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_MODE  = 2'd2;

	localparam logic [SIDE_W-1:0] MIN_SIDE_LOG2 = 4'd3;

	// Index bytes of a VQ texture follow its codebook.
	localparam logic [ADDR_W-1:0] VQ_CODEBOOK_BYTES = 22'd2048;

	typedef enum logic [MODE_W-1:0] {
		MODE_TWIDDLED     = 3'd0,
		MODE_TWIDDLED_MIP = 3'd1,
		MODE_VQ           = 3'd2,
		MODE_VQ_MIP       = 3'd3,
		MODE_RECT         = 3'd4,
		MODE_RECT_MIP     = 3'd5
	} mode_t;

	// Effective configuration: sides already clamped, mode already decoded.
	typedef struct packed {
		logic [SIDE_W-1:0] width_log2;
		logic [SIDE_W-1:0] height_log2;
		mode_t             image_mode;
	} cfg_t;

	// Mipmap base offsets, selected by width_log2 minus three.
	localparam logic [BASE_W-1:0] MIP_BASE_PLAIN [8] = '{
		20'h00030, 20'h000B0, 20'h002B0, 20'h00AB0,
		20'h02AB0, 20'h0AAB0, 20'h2AAB0, 20'hAAAB0
	};

	localparam logic [BASE_W-1:0] MIP_BASE_VQ [8] = '{
		20'h00006, 20'h00016, 20'h00056, 20'h00156,
		20'h00556, 20'h01556, 20'h05556, 20'h15556
	};

endpackage

`default_nettype wire

// ===== design/pvrtag_cfg.sv =====
`default_nettype none

`include "pvr_texel_address_generator_top_defines.svh"

module pvrtag_cfg #(
	parameter int MAX_SIDE_LOG2 = 10
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                wr_en,
	input  wire logic [pvrtag_pkg::CFG_IDX_W-1:0]    wr_index,
	input  wire logic [pvrtag_pkg::CFG_DATA_W-1:0]   wr_data,
	output pvrtag_pkg::cfg_t                         cfg
);

	import pvrtag_pkg::*;

	localparam logic [SIDE_W-1:0] MAX_SIDE = SIDE_W'(MAX_SIDE_LOG2);

	logic [SIDE_W-1:0] width_log2_q;
	logic [SIDE_W-1:0] height_log2_q;
	logic [MODE_W-1:0] image_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_log2_q  <= MIN_SIDE_LOG2;
			height_log2_q <= MIN_SIDE_LOG2;
			image_mode_q  <= MODE_TWIDDLED;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_WIDTH_LOG2:  width_log2_q  <= wr_data[SIDE_W-1:0];
				REG_HEIGHT_LOG2: height_log2_q <= wr_data[SIDE_W-1:0];
				REG_IMAGE_MODE:  image_mode_q  <= wr_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		r = v;
		if (v < MIN_SIDE_LOG2) r = MIN_SIDE_LOG2;
		else if (v > MAX_SIDE) r = MAX_SIDE;
		return r;
	endfunction

	always_comb begin
		cfg.width_log2  = clamp_side(width_log2_q);
		cfg.height_log2 = clamp_side(height_log2_q);
		// The two unused mode codes behave as plain twiddled.
		unique case (image_mode_q)
			MODE_TWIDDLED_MIP: cfg.image_mode = MODE_TWIDDLED_MIP;
			MODE_VQ:           cfg.image_mode = MODE_VQ;
			MODE_VQ_MIP:       cfg.image_mode = MODE_VQ_MIP;
			MODE_RECT:         cfg.image_mode = MODE_RECT;
			MODE_RECT_MIP:     cfg.image_mode = MODE_RECT_MIP;
			default:           cfg.image_mode = MODE_TWIDDLED;
		endcase
	end

	`PVR_ASSERT(a_sides_in_range, clk, arst_n, cfg.width_log2 >= MIN_SIDE_LOG2 && cfg.width_log2 <= MAX_SIDE && cfg.height_log2 >= MIN_SIDE_LOG2 && cfg.height_log2 <= MAX_SIDE)

endmodule

`default_nettype wire

// ===== design/pvrtag_addr.sv =====
`default_nettype none

module pvrtag_addr (
	input  wire pvrtag_pkg::cfg_t                  cfg,
	input  wire logic [pvrtag_pkg::COORD_W-1:0]    x_in,
	input  wire logic [pvrtag_pkg::COORD_W-1:0]    y_in,
	output logic      [pvrtag_pkg::ADDR_W-1:0]     byte_address,
	output logic      [pvrtag_pkg::SLOT_W-1:0]     codebook_slot
);

	import pvrtag_pkg::*;

	// Interleave y into even and x into odd bits over the shorter side, then
	// append the leftover bits of the longer side above.
	function automatic logic [IDX_W-1:0] twiddle(
		input logic [COORD_W-1:0] x,
		input logic [COORD_W-1:0] y,
		input logic [SIDE_W-1:0]  wl,
		input logic [SIDE_W-1:0]  hl
	);
		logic [IDX_W-1:0] idx;
		logic [4:0]       pos;
		idx = '0;
		pos = '0;
		for (int i = 0; i < COORD_W; i++) begin
			if (SIDE_W'(i) < wl && SIDE_W'(i) < hl) begin
				idx[2*i]     = y[i];
				idx[2*i + 1] = x[i];
			end else if (SIDE_W'(i) < wl) begin
				pos = 5'(i) + 5'(hl);
				idx[pos] = x[i];
			end else if (SIDE_W'(i) < hl) begin
				pos = 5'(i) + 5'(wl);
				idx[pos] = y[i];
			end
		end
		return idx;
	endfunction

	logic [COORD_W-1:0] x_m;
	logic [COORD_W-1:0] y_m;
	logic [2:0]         sel;
	logic [IDX_W-1:0]   tw_plain;
	logic [IDX_W-1:0]   tw_vq;
	logic [IDX_W-1:0]   rect_idx;
	logic [BASE_W-1:0]  base;

	always_comb begin
		x_m = x_in & ~({COORD_W{1'b1}} << cfg.width_log2);
		y_m = y_in & ~({COORD_W{1'b1}} << cfg.height_log2);
		sel = 3'(cfg.width_log2 - MIN_SIDE_LOG2);

		tw_plain = twiddle(x_m, y_m, cfg.width_log2, cfg.height_log2);
		tw_vq    = twiddle({1'b0, x_m[COORD_W-1:1]}, {1'b0, y_m[COORD_W-1:1]},
			cfg.width_log2 - 4'd1, cfg.height_log2 - 4'd1);
		// Masked x never reaches the row bits, so the add is an OR.
		rect_idx = (IDX_W'(y_m) << cfg.width_log2) | IDX_W'(x_m);

		base          = '0;
		codebook_slot = '0;
		case (cfg.image_mode) inside
			MODE_VQ, MODE_VQ_MIP: begin
				if (cfg.image_mode == MODE_VQ_MIP) base = MIP_BASE_VQ[sel];
				byte_address  = VQ_CODEBOOK_BYTES + ADDR_W'(base) + ADDR_W'(tw_vq);
				codebook_slot = {x_m[0], y_m[0]};
			end
			MODE_RECT, MODE_RECT_MIP: begin
				if (cfg.image_mode == MODE_RECT_MIP) base = MIP_BASE_PLAIN[sel];
				byte_address = ADDR_W'(base) + ADDR_W'({rect_idx, 1'b0});
			end
			default: begin
				if (cfg.image_mode == MODE_TWIDDLED_MIP) base = MIP_BASE_PLAIN[sel];
				byte_address = ADDR_W'(base) + ADDR_W'({tw_plain, 1'b0});
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/pvr_texel_address_generator_top.sv =====
// Texel address generator: one coordinate in, one byte offset out, every
// clock. A word is taken whenever start is high and busy is low; busy is never
// raised, so a new coordinate may be offered in every cycle. Each result is
// registered in the input register and then the result register, with the
// whole address sum between them, and is shown for exactly one cycle with done
// high. The receiver cannot stall the block: done drops after that cycle
// whether the result was used or not, so whatever consumes it must be ready to
// take one word per clock.
// Configuration registers (width_log2, height_log2, image_mode) are written
// through their own channel, which is always ready; they must only be changed
// while no coordinate is in flight.
`default_nettype none

`include "pvr_texel_address_generator_top_defines.svh"

module pvr_texel_address_generator_top #(
	parameter int MAX_SIDE_LOG2 = 10
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// Coordinate channel.
	input  wire logic                                start,
	output logic                                     busy,
	input  wire logic [pvrtag_pkg::COORD_W-1:0]      x_coord,
	input  wire logic [pvrtag_pkg::COORD_W-1:0]      y_coord,
	// Result channel.
	output logic                                     done,
	output logic      [pvrtag_pkg::ADDR_W-1:0]       byte_address,
	output logic      [pvrtag_pkg::SLOT_W-1:0]       codebook_slot,
	// Configuration write channel.
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [pvrtag_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [pvrtag_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import pvrtag_pkg::*;

	cfg_t               cfg;
	logic               accept;
	logic               valid_s1;
	logic [COORD_W-1:0] x_s1;
	logic [COORD_W-1:0] y_s1;
	logic [ADDR_W-1:0]  addr_comb;
	logic [SLOT_W-1:0]  slot_comb;
	logic               is_vq;

	// The pipeline never holds anything back, so neither side is ever refused.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	pvrtag_cfg #(
		.MAX_SIDE_LOG2(MAX_SIDE_LOG2)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// Stage one: the coordinate is registered as it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1 <= x_coord;
			y_s1 <= y_coord;
		end
	end

	// Masking, interleaving and the base offset sum all sit in this one stage.
	pvrtag_addr u_addr (
		.cfg           (cfg),
		.x_in          (x_s1),
		.y_in          (y_s1),
		.byte_address  (addr_comb),
		.codebook_slot (slot_comb)
	);

	// Stage two: the result register drives the ports directly, so done is a
	// single-cycle strobe for every word that was taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			byte_address  <= addr_comb;
			codebook_slot <= slot_comb;
		end
	end

	assign is_vq = (cfg.image_mode == MODE_VQ) || (cfg.image_mode == MODE_VQ_MIP);

	// Every taken word gives exactly one result, through the stage-one and result registers.
	`PVR_ASSERT_NEXT(a_s1_to_done, clk, arst_n, valid_s1, done)
	`PVR_ASSERT(a_done_has_source, clk, arst_n, done |-> $past(accept, 2))
	// Only VQ modes name a codebook slot.
	`PVR_ASSERT(a_slot_only_vq, clk, arst_n, (valid_s1 && !is_vq) |-> (slot_comb == '0))
	// VQ index bytes lie past the codebook; texel words are 16-bit aligned.
	`PVR_ASSERT(a_addr_shape, clk, arst_n, valid_s1 |-> (is_vq ? (addr_comb >= VQ_CODEBOOK_BYTES) : (addr_comb[0] == 1'b0)))

endmodule

`default_nettype wire
